### rtl/core/srecord_s3_encoder_assert.svh
// Assertion macros for the S-record encoder checks
`ifndef SRECORD_S3_ENCODER_ASSERT_SVH
`define SRECORD_S3_ENCODER_ASSERT_SVH

// Check a property on every rising clock edge outside reset
`define SREC_CHECK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds outside reset
`define SREC_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### rtl/core/srec_pkg.sv
// Shared types, constants and character functions of the S3 record encoder
package srec_pkg;

	localparam logic [1:0] REG_START_ADDRESS = 2'd0;
	localparam logic [1:0] REG_TOTAL_BYTES   = 2'd1;
	localparam logic [1:0] REG_LINE_END_MODE = 2'd2;

	localparam logic [1:0] LE_CR   = 2'd0;
	localparam logic [1:0] LE_LF   = 2'd1;
	localparam logic [1:0] LE_CRLF = 2'd2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPW         = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_S  = 8'h53;
	localparam logic [7:0] CH_3  = 8'h33;

	localparam logic [3:0] HDR_LAST  = 4'd11;
	localparam logic [3:0] TERM_LAST = 4'd13;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HDR,
		PH_DATA,
		PH_SUM,
		PH_EOL,
		PH_TERM,
		PH_TEOL
	} phase_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        hdr;
		logic [7:0]  cnt;
		logic [31:0] addr;
		logic        trl;
		logic [7:0]  sum;
		logic        term;
		logic [1:0]  eol;
	} cmd_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = 8'h30 + {4'h0, nib};
		end else begin
			r = 8'h37 + {4'h0, nib};
		end
		return r;
	endfunction

	function automatic logic [7:0] term_char(input logic [3:0] idx);
		logic [7:0] r;
		case (idx)
			4'd0:    r = 8'h53;
			4'd1:    r = 8'h37;
			4'd3:    r = 8'h35;
			4'd12:   r = 8'h46;
			4'd13:   r = 8'h41;
			default: r = 8'h30;
		endcase
		return r;
	endfunction

endpackage

### rtl/core/srec_front.sv
// Front end: accepts data bytes, tracks record state and builds commands
module srec_front #(
	parameter int RECORD_BYTES = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          data_byte,
	input  logic [31:0]         start_address,
	input  logic [31:0]         total_bytes,
	input  logic [1:0]          line_end_mode,
	input  logic                q_full,
	output logic                push,
	output srec_pkg::cmd_t      cmd
);

	localparam int          LW   = $clog2(RECORD_BYTES + 1);
	localparam logic [31:0] RB32 = 32'(RECORD_BYTES);

	logic           in_dump_q;
	logic [31:0]    addr_q;
	logic [31:0]    rem_q;
	logic [LW-1:0]  fill_q;
	logic [LW-1:0]  len_q;
	logic [7:0]     sum_q;

	logic [31:0]    cur_addr;
	logic [31:0]    cur_rem;
	logic [LW-1:0]  cur_fill;
	logic           hdr;
	logic [LW-1:0]  len;
	logic [7:0]     cnt;
	logic [7:0]     base;
	logic [7:0]     sum_new;
	logic [LW-1:0]  fill_new;
	logic           trl;
	logic [31:0]    rem_new;
	logic           term;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		cur_addr = in_dump_q ? addr_q : start_address;
		if (in_dump_q) begin
			cur_rem = rem_q;
		end else begin
			cur_rem = (total_bytes == 32'd0) ? 32'd1 : total_bytes;
		end
		cur_fill = in_dump_q ? fill_q : '0;
		hdr      = (cur_fill == '0);
		if (hdr) begin
			len = (cur_rem < RB32) ? cur_rem[LW-1:0] : RB32[LW-1:0];
		end else begin
			len = len_q;
		end
		cnt = 8'(len) + 8'd5;
		if (hdr) begin
			base = cnt + cur_addr[31:24] + cur_addr[23:16] + cur_addr[15:8] + cur_addr[7:0];
		end else begin
			base = sum_q;
		end
		sum_new  = base + data_byte;
		fill_new = LW'(cur_fill + 1'b1);
		trl      = (fill_new >= len);
		rem_new  = cur_rem - 32'(len);
		term     = trl && (rem_new == 32'd0);

		cmd.data = data_byte;
		cmd.hdr  = hdr;
		cmd.cnt  = cnt;
		cmd.addr = cur_addr;
		cmd.trl  = trl;
		cmd.sum  = ~sum_new;
		cmd.term = term;
		cmd.eol  = line_end_mode;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_dump_q <= 1'b0;
			fill_q    <= '0;
		end else if (push) begin
			if (trl) begin
				fill_q    <= '0;
				in_dump_q <= !term;
			end else begin
				fill_q    <= fill_new;
				in_dump_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			len_q  <= len;
			sum_q  <= sum_new;
			addr_q <= trl ? (cur_addr + 32'(len)) : cur_addr;
			rem_q  <= trl ? rem_new : cur_rem;
		end
	end

endmodule

### rtl/core/srec_queue.sv
// Short command queue between the front end and the character sequencer
module srec_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  srec_pkg::cmd_t  push_cmd,
	input  logic            pop,
	output srec_pkg::cmd_t  head,
	output logic            full,
	output logic            empty
);

	srec_pkg::cmd_t            mem_q [srec_pkg::QUEUE_DEPTH];
	logic [srec_pkg::QPW-1:0]  wr_q;
	logic [srec_pkg::QPW-1:0]  rd_q;
	logic [srec_pkg::QPW:0]    cnt_q;

	assign full  = (cnt_q == (srec_pkg::QPW + 1)'(srec_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == srec_pkg::QPW'(srec_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == srec_pkg::QPW'(srec_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

endmodule

### rtl/core/srec_back.sv
// Back end: walks each command through its characters into the output register
module srec_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  srec_pkg::cmd_t  head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_char,
	output logic            dump_done
);

	srec_pkg::phase_t  state_q;
	srec_pkg::phase_t  state_d;
	srec_pkg::phase_t  step_state;
	logic [3:0]        idx_q;
	logic [3:0]        idx_d;
	logic [3:0]        step_idx;
	srec_pkg::cmd_t    cmd_q;

	logic              out_valid_q;
	logic [7:0]        out_char_q;
	logic              dump_done_q;

	logic              advance;
	logic              emit;
	logic              fin;
	logic              load;
	logic              eol_end;
	logic [7:0]        ch;
	logic              done;
	logic [2:0]        ni;
	logic [3:0]        nib;

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign dump_done = dump_done_q;
	assign pop       = load;

	always_comb begin
		advance    = !out_valid_q || out_ready;
		emit       = (state_q != srec_pkg::PH_IDLE) && advance;
		eol_end    = (cmd_q.eol == srec_pkg::LE_CR) || (cmd_q.eol == srec_pkg::LE_LF) ||
		             (idx_q == 4'd1);
		ni         = 3'(srec_pkg::HDR_LAST - idx_q);
		nib        = 4'(cmd_q.addr >> {ni, 2'b00});
		ch         = srec_pkg::CH_S;
		done       = 1'b0;
		fin        = 1'b0;
		step_state = state_q;
		step_idx   = idx_q + 4'd1;

		case (state_q)
			srec_pkg::PH_HDR: begin
				case (idx_q)
					4'd0:    ch = srec_pkg::CH_S;
					4'd1:    ch = srec_pkg::CH_3;
					4'd2:    ch = srec_pkg::hex_char(cmd_q.cnt[7:4]);
					4'd3:    ch = srec_pkg::hex_char(cmd_q.cnt[3:0]);
					default: ch = srec_pkg::hex_char(nib);
				endcase
				if (idx_q == srec_pkg::HDR_LAST) begin
					step_state = srec_pkg::PH_DATA;
					step_idx   = 4'd0;
				end
			end
			srec_pkg::PH_DATA: begin
				ch = srec_pkg::hex_char((idx_q == 4'd0) ? cmd_q.data[7:4] : cmd_q.data[3:0]);
				if (idx_q == 4'd1) begin
					step_idx = 4'd0;
					if (cmd_q.trl) begin
						step_state = srec_pkg::PH_SUM;
					end else begin
						fin = 1'b1;
					end
				end
			end
			srec_pkg::PH_SUM: begin
				ch = srec_pkg::hex_char((idx_q == 4'd0) ? cmd_q.sum[7:4] : cmd_q.sum[3:0]);
				if (idx_q == 4'd1) begin
					step_state = srec_pkg::PH_EOL;
					step_idx   = 4'd0;
				end
			end
			srec_pkg::PH_EOL: begin
				ch = ((cmd_q.eol == srec_pkg::LE_LF) || (idx_q == 4'd1)) ?
				     srec_pkg::CH_LF : srec_pkg::CH_CR;
				if (eol_end) begin
					step_idx = 4'd0;
					if (cmd_q.term) begin
						step_state = srec_pkg::PH_TERM;
					end else begin
						fin = 1'b1;
					end
				end
			end
			srec_pkg::PH_TERM: begin
				ch = srec_pkg::term_char(idx_q);
				if (idx_q == srec_pkg::TERM_LAST) begin
					step_state = srec_pkg::PH_TEOL;
					step_idx   = 4'd0;
				end
			end
			srec_pkg::PH_TEOL: begin
				ch = ((cmd_q.eol == srec_pkg::LE_LF) || (idx_q == 4'd1)) ?
				     srec_pkg::CH_LF : srec_pkg::CH_CR;
				if (eol_end) begin
					done = 1'b1;
					fin  = 1'b1;
				end
			end
			default: begin
				step_idx = idx_q;
			end
		endcase

		load = ((state_q == srec_pkg::PH_IDLE) || (emit && fin)) && !q_empty;

		if (load) begin
			state_d = head.hdr ? srec_pkg::PH_HDR : srec_pkg::PH_DATA;
			idx_d   = 4'd0;
		end else if (emit && fin) begin
			state_d = srec_pkg::PH_IDLE;
			idx_d   = 4'd0;
		end else if (emit) begin
			state_d = step_state;
			idx_d   = step_idx;
		end else begin
			state_d = state_q;
			idx_d   = idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= srec_pkg::PH_IDLE;
			idx_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= head;
		end
		if (emit) begin
			out_char_q  <= ch;
			dump_done_q <= done;
		end
	end

endmodule

### rtl/core/srecord_s3_encoder.sv
// Top level of the S3 record encoder
//
// Data bytes enter on in_valid/in_ready/data_byte; record text leaves one
// ASCII character per item on out_valid/out_ready/out_char, with dump_done
// set on the last character of the S7 terminator line. The user must write
// registers via cfg_we/cfg_index/cfg_data only while the block is idle (not
// enforced by the block): index 0 start address, 1 total byte count, 2 line-end mode.
// With the sequencer idle, the first character of a record passes the queue,
// the command register and the output register once its byte is accepted.
// Throughput: one character per cycle while out_ready is high, set by the
// character sequencer. A byte costs two characters; a record adds a
// 12-character header and a 3 or 4 character trailer, so a full 32-byte record
// takes about 2.5 characters per byte. The terminator adds 15 or 16 characters.
// A two-entry command queue lets the front end take bytes while the
// sequencer works; in_ready drops when that queue is full.
// When the receiver stalls, the output register holds its character and the
// queue fills, then the input stalls. Reset clears all record state, empties
// the queue and restores the register defaults.
module srecord_s3_encoder #(
	parameter int RECORD_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_char,
	output logic        dump_done
);

	logic [31:0]     start_address_q;
	logic [31:0]     total_bytes_q;
	logic [1:0]      line_end_mode_q;

	logic            push;
	logic            pop;
	logic            q_full;
	logic            q_empty;
	srec_pkg::cmd_t  push_cmd;
	srec_pkg::cmd_t  head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_address_q <= 32'd0;
			total_bytes_q   <= 32'd1;
			line_end_mode_q <= srec_pkg::LE_CRLF;
		end else if (cfg_we) begin
			case (cfg_index)
				srec_pkg::REG_START_ADDRESS: start_address_q <= cfg_data;
				srec_pkg::REG_TOTAL_BYTES:   total_bytes_q   <= cfg_data;
				srec_pkg::REG_LINE_END_MODE: line_end_mode_q <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	srec_front #(
		.RECORD_BYTES(RECORD_BYTES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.start_address (start_address_q),
		.total_bytes   (total_bytes_q),
		.line_end_mode (line_end_mode_q),
		.q_full        (q_full),
		.push          (push),
		.cmd           (push_cmd)
	);

	srec_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	srec_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.dump_done (dump_done)
	);

endmodule

### rtl/core/srec_checker.sv
// Port-level checks of the S3 record encoder output stream and their binding
`include "srecord_s3_encoder_assert.svh"

module srec_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       dump_done
);

	`SREC_CHECK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(dump_done), "output item changed while stalled")
	`SREC_NEVER(a_done_on_eol, out_valid && dump_done && out_char != 8'h0d && out_char != 8'h0a, "dump_done off a line-end character")
	`SREC_CHECK(a_next_is_s, out_valid && out_ready && dump_done |=> !out_valid || out_char == 8'h53, "text after terminator does not open a record")

endmodule

bind srecord_s3_encoder srec_checker u_srec_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_char  (out_char),
	.dump_done (dump_done)
);
